/* src/rsd_pkg.sv */
`default_nettype none
package rsd_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 29;
	localparam int unsigned FLAG_LSB = 29;
	localparam int unsigned RES_PER_WORD = 4;
	localparam logic [31:0] SYNC_RESET = 32'hced7230a;

	localparam logic [1:0] PH_MAGIC   = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_HALT    = 2'd3;

	localparam logic [2:0] ERR_NONE           = 3'd0;
	localparam logic [2:0] ERR_MAGIC          = 3'd1;
	localparam logic [2:0] ERR_CONT_AT_START  = 3'd2;
	localparam logic [2:0] ERR_START_IN_SPLIT = 3'd3;
	localparam logic [2:0] ERR_TRUNC          = 3'd4;

	typedef struct packed {
		logic [31:0] data_word;
		logic        stream_end;
	} in_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       byte_valid;
		logic       record_last;
		logic [2:0] error_code;
	} out_t;

	// framing control state; the byte count travels beside it
	typedef struct packed {
		logic [1:0] phase;
		logic       part_flag;
		logic       inside_split;
	} ctl_t;

endpackage
`default_nettype wire

/* src/rsd_decode.sv */
`default_nettype none
module rsd_decode #(
	parameter int unsigned LENGTH_BITS = rsd_pkg::LENGTH_BITS_DEF
) (
	input  wire rsd_pkg::in_t                     item,
	input  wire logic [31:0]                      sync_word,
	input  wire rsd_pkg::ctl_t                    ctl,
	input  wire logic [LENGTH_BITS-1:0]           remaining,
	output rsd_pkg::ctl_t                         ctl_nxt,
	output logic [LENGTH_BITS-1:0]                remaining_nxt,
	output rsd_pkg::out_t [rsd_pkg::RES_PER_WORD-1:0] res,
	output logic [2:0]                            res_cnt
);

	logic [2:0]             flag;
	logic [LENGTH_BITS-1:0] len;
	logic                   len_zero;
	logic                   cont;
	logic                   rem_ge4;
	logic                   rem_le4;
	logic [2:0]             take;

	assign flag     = item.data_word[31:rsd_pkg::FLAG_LSB];
	assign len      = item.data_word[LENGTH_BITS-1:0];
	assign len_zero = (len == '0);
	assign rem_ge4  = |remaining[LENGTH_BITS-1:2];
	// the part ends within this word
	assign rem_le4  = (remaining <= LENGTH_BITS'(4));
	assign take     = rem_ge4 ? 3'd4 : {1'b0, remaining[1:0]};

	always_comb begin
		priority if (flag <= 3'd1) begin
			cont = flag[0];
		end else if (flag <= 3'd3) begin
			cont = (flag == 3'd2);
		end else begin
			cont = 1'b1;
		end
	end

	always_comb begin
		ctl_nxt       = ctl;
		remaining_nxt = remaining;
		res           = '0;
		res_cnt       = 3'd0;
		if (ctl.phase == rsd_pkg::PH_HALT) begin
			res_cnt = 3'd0;
		end else if (item.stream_end) begin
			if (!(ctl.phase == rsd_pkg::PH_MAGIC && !ctl.inside_split)) begin
				res[0].error_code = rsd_pkg::ERR_TRUNC;
				res_cnt           = 3'd1;
				ctl_nxt.phase     = rsd_pkg::PH_HALT;
			end
		end else begin
			unique case (ctl.phase)
				rsd_pkg::PH_MAGIC: begin
					if (item.data_word != sync_word) begin
						res[0].error_code = rsd_pkg::ERR_MAGIC;
						res_cnt           = 3'd1;
						ctl_nxt.phase     = rsd_pkg::PH_HALT;
					end else begin
						ctl_nxt.phase = rsd_pkg::PH_HEADER;
					end
				end
				rsd_pkg::PH_HEADER: begin
					if (flag <= 3'd1 && ctl.inside_split) begin
						res[0].error_code = rsd_pkg::ERR_START_IN_SPLIT;
						res_cnt           = 3'd1;
						ctl_nxt.phase     = rsd_pkg::PH_HALT;
					end else if ((flag == 3'd2 || flag == 3'd3) && !ctl.inside_split) begin
						res[0].error_code = rsd_pkg::ERR_CONT_AT_START;
						res_cnt           = 3'd1;
						ctl_nxt.phase     = rsd_pkg::PH_HALT;
					end else begin
						if (ctl.inside_split) begin
							// re-insert the sync bytes between joined parts
							for (int i = 0; i < rsd_pkg::RES_PER_WORD; i++) begin
								res[i].payload_byte = sync_word[8*i +: 8];
								res[i].byte_valid   = 1'b1;
							end
							res[rsd_pkg::RES_PER_WORD-1].record_last = len_zero && !cont;
							res_cnt = 3'd4;
						end else if (len_zero && !cont) begin
							res[0].record_last = 1'b1;
							res_cnt            = 3'd1;
						end
						ctl_nxt.inside_split = cont;
						ctl_nxt.part_flag    = cont;
						remaining_nxt        = len;
						ctl_nxt.phase = len_zero ? rsd_pkg::PH_MAGIC : rsd_pkg::PH_PAYLOAD;
					end
				end
				rsd_pkg::PH_PAYLOAD: begin
					for (int i = 0; i < rsd_pkg::RES_PER_WORD; i++) begin
						if (3'(i) < take) begin
							res[i].payload_byte = item.data_word[8*i +: 8];
							res[i].byte_valid   = 1'b1;
							res[i].record_last  = !ctl.part_flag
								&& (remaining == LENGTH_BITS'(i + 1));
						end
					end
					res_cnt       = take;
					remaining_nxt = remaining - LENGTH_BITS'(take);
					if (rem_le4) begin
						ctl_nxt.phase = rsd_pkg::PH_MAGIC;
					end
				end
				default: begin
					ctl_nxt = ctl;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/record_stream_deframer.sv */
// An accepted word waits in the input register, then its results load the result buffer.
// Throughput: one word per cycle while each word yields at most one result and res_ready
// is high; a word with more results holds the result buffer until they are taken, so payload
// words go no faster than their bytes leave, one byte per request on the single result port.
// Reset (arst_n low, asynchronous): expect a magic word, no split open, byte count zero,
// sync_word back to its default, input and result buffers empty.
`default_nettype none
module record_stream_deframer #(
	parameter int unsigned LENGTH_BITS = rsd_pkg::LENGTH_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sync_we,
	input  wire logic [31:0]   sync_wdata,
	input  wire logic          word_valid,
	output logic               word_ready,
	input  wire rsd_pkg::in_t  word,
	output logic               res_valid,
	input  wire logic          res_ready,
	output rsd_pkg::out_t      res
);

	// configuration
	logic [31:0] sync_q;

	// input register
	rsd_pkg::in_t word_s1;
	logic         valid_s1;

	// framing state
	rsd_pkg::ctl_t          ctl_q;
	logic [LENGTH_BITS-1:0] remaining_q;

	// result buffer: the up-to-four results of one word, drained one per request
	rsd_pkg::out_t [rsd_pkg::RES_PER_WORD-1:0] grp_s2;
	logic [2:0] cnt_q;
	logic [1:0] idx_q;

	// decoder outputs
	rsd_pkg::ctl_t                             ctl_nxt;
	logic [LENGTH_BITS-1:0]                    remaining_nxt;
	rsd_pkg::out_t [rsd_pkg::RES_PER_WORD-1:0] dec_res;
	logic [2:0]                                dec_cnt;

	logic grp_free;
	logic process;
	logic res_take;

	rsd_decode #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_decode (
		.item         (word_s1),
		.sync_word    (sync_q),
		.ctl          (ctl_q),
		.remaining    (remaining_q),
		.ctl_nxt      (ctl_nxt),
		.remaining_nxt(remaining_nxt),
		.res          (dec_res),
		.res_cnt      (dec_cnt)
	);

	assign res_valid = (cnt_q != 3'd0);
	assign res       = grp_s2[idx_q];
	assign res_take  = res_valid && res_ready;

	// buffer is free once empty, or when its final result leaves this cycle
	assign grp_free   = (cnt_q == 3'd0) || (cnt_q == 3'd1 && res_ready);
	assign process    = valid_s1 && grp_free;
	// take a new request whenever the held one is being decoded or none is held
	assign word_ready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= rsd_pkg::SYNC_RESET;
		end else if (sync_we) begin
			sync_q <= sync_wdata;
		end
	end

	// input register: hold the word until the result buffer can take its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (word_ready) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_ready && word_valid) begin
			word_s1 <= word;
		end
	end

	// advance framing state once per decoded word; a halted decoder keeps its state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase        <= rsd_pkg::PH_MAGIC;
			ctl_q.part_flag    <= 1'b0;
			ctl_q.inside_split <= 1'b0;
			remaining_q        <= '0;
		end else if (process) begin
			ctl_q       <= ctl_nxt;
			remaining_q <= remaining_nxt;
		end
	end

	// result count and read pointer: load on decode, otherwise step on each taken request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (process) begin
			cnt_q <= dec_cnt;
			idx_q <= 2'd0;
		end else if (res_take) begin
			cnt_q <= cnt_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			grp_s2 <= dec_res;
		end
	end

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	// Timing of the run; the limit is many times the slowest legal run
	localparam int unsigned HALF_PERIOD  = 4;
	localparam int unsigned RESET_CYCLES = 11;
	localparam int unsigned SETTLE_CYCLES = 10;   // a word with no result may still be in flight
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off, fills the block
	localparam int unsigned SEG_WORDS    = 62;    // random words per sync_word setting
	localparam int unsigned LIMIT_NS     = 2_000_000;

	typedef struct {
		rsd_pkg::in_t  item;
		int            n_typed;   // -1: take the predictor's results, else the typed count
		rsd_pkg::out_t typed;
	} stim_row_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  sync_we;
	logic  [31:0] sync_wdata;
	logic  word_valid;
	logic  word_ready;
	rsd_pkg::in_t  word;
	logic  res_valid;
	logic  res_ready;
	rsd_pkg::out_t res;

	// Predictor state, a private copy of the framing machine
	logic  [1:0]  pr_phase;
	logic         pr_cont;
	logic         pr_split;
	logic  [28:0] pr_left;
	logic  [31:0] pr_sync;

	rsd_pkg::out_t awaited_res[$];
	rsd_pkg::out_t want_res;
	int    fail_count = 0;
	int    burst_left = 0;
	int    words_sent = 0;
	bit    hold_req = 1'b0;

	stim_row_t dir_rows[$];
	stim_row_t tail_rows[$];

	record_stream_deframer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sync_we    (sync_we),
		.sync_wdata (sync_wdata),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function automatic void add_dir_row(input stim_row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	function automatic void add_tail_row(input stim_row_t r);
		tail_rows.insert(tail_rows.size(), r);
	endfunction

	function automatic void await_result(input rsd_pkg::out_t r);
		awaited_res.insert(awaited_res.size(), r);
	endfunction

	function automatic rsd_pkg::in_t mk_in(input logic [31:0] w, input logic e);
		rsd_pkg::in_t t;
		t.data_word  = w;
		t.stream_end = e;
		return t;
	endfunction

	function automatic rsd_pkg::out_t mk_res(input logic [7:0] b, input logic v, input logic l,
			input logic [2:0] e);
		rsd_pkg::out_t t;
		t.payload_byte = b;
		t.byte_valid   = v;
		t.record_last  = l;
		t.error_code   = e;
		return t;
	endfunction

	function automatic stim_row_t mk_row(input logic [31:0] w, input logic e, input int n,
			input rsd_pkg::out_t t);
		stim_row_t r;
		r.item    = mk_in(w, e);
		r.n_typed = n;
		r.typed   = t;
		return r;
	endfunction

	// Advance the private framing machine by one word and return the bytes it releases
	function automatic int deframe_word(input rsd_pkg::in_t it, output rsd_pkg::out_t r[4]);
		logic [2:0] flag;
		logic [28:0] len;
		logic cont;
		logic [2:0] err;
		int n;
		n = 0;
		err = rsd_pkg::ERR_NONE;
		for (int i = 0; i < 4; i++)
			r[i] = '0;
		if (pr_phase == rsd_pkg::PH_HALT)
			return 0;
		if (it.stream_end) begin
			// end between records is harmless; anywhere else the record is cut short
			if (pr_phase != rsd_pkg::PH_MAGIC || pr_split)
				err = rsd_pkg::ERR_TRUNC;
		end else if (pr_phase == rsd_pkg::PH_MAGIC) begin
			if (it.data_word != pr_sync)
				err = rsd_pkg::ERR_MAGIC;
			else
				pr_phase = rsd_pkg::PH_HEADER;
		end else if (pr_phase == rsd_pkg::PH_HEADER) begin
			flag = it.data_word[31:29];
			len  = it.data_word[28:0];
			if (flag <= 3'd1) begin
				cont = flag[0];
				if (pr_split)
					err = rsd_pkg::ERR_START_IN_SPLIT;
			end else if (flag <= 3'd3) begin
				cont = (flag == 3'd2);
				if (!pr_split)
					err = rsd_pkg::ERR_CONT_AT_START;
			end else begin
				cont = 1'b1;
			end
			if (err == rsd_pkg::ERR_NONE) begin
				if (pr_split) begin
					// re-insert the sync bytes between joined parts
					for (int i = 0; i < 4; i++) begin
						r[n] = mk_res(pr_sync[8*i +: 8], 1'b1,
							(i == 3 && len == 0 && !cont), rsd_pkg::ERR_NONE);
						n++;
					end
				end else if (len == 0 && !cont) begin
					r[n] = mk_res(8'h00, 1'b0, 1'b1, rsd_pkg::ERR_NONE);
					n++;
				end
				pr_split = cont;
				pr_cont  = cont;
				pr_left  = len;
				pr_phase = (len == 0) ? rsd_pkg::PH_MAGIC : rsd_pkg::PH_PAYLOAD;
			end
		end else begin
			for (int i = 0; i < 4 && pr_left != 0; i++) begin
				pr_left = pr_left - 29'd1;
				r[n] = mk_res(it.data_word[8*i +: 8], 1'b1, (pr_left == 0 && !pr_cont),
					rsd_pkg::ERR_NONE);
				n++;
			end
			if (pr_left == 0)
				pr_phase = rsd_pkg::PH_MAGIC;
		end
		if (err != rsd_pkg::ERR_NONE) begin
			r[0] = mk_res(8'h00, 1'b0, 1'b0, err);
			pr_phase = rsd_pkg::PH_HALT;
			n = 1;
		end
		return n;
	endfunction

	// Offer one word request; entered and left just after a falling edge.
	// Hold the request until the block takes it, then queue what it must produce.
	task automatic offer_word(input rsd_pkg::in_t it, input int n_typed,
			input rsd_pkg::out_t typed);
		int gap;
		int n;
		rsd_pkg::out_t pred_r[4];
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				word_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		word       <= it;
		word_valid <= 1'b1;
		do
			@(posedge clk);
		while (!word_ready);
		burst_left--;
		if (!it.stream_end)
			words_sent++;
		n = deframe_word(it, pred_r);
		if (n_typed < 0) begin
			for (int i = 0; i < n; i++)
				await_result(pred_r[i]);
		end else if (n_typed == 1) begin
			await_result(typed);
		end
		@(negedge clk);
	endtask

	// Change sync_word only once the block has gone quiet
	task automatic load_sync(input logic [31:0] v);
		word_valid <= 1'b0;
		while (awaited_res.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		sync_we    <= 1'b1;
		sync_wdata <= v;
		@(negedge clk);
		sync_we <= 1'b0;
		pr_sync = v;
	endtask

	// One well-formed record with random content, split into parts now and then
	task automatic gen_record();
		int nparts;
		logic [2:0] flag;
		int len;
		if ($urandom_range(0, 9) == 0)
			offer_word(mk_in($urandom, 1'b1), -1, '0);
		nparts = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : 1;
		for (int p = 0; p < nparts; p++) begin
			if (nparts == 1)
				flag = 3'd0;
			else if (p == nparts - 1)
				flag = 3'd3;
			else if (p == 0)
				flag = $urandom_range(0, 1) ? 3'd1 : 3'($urandom_range(4, 7));
			else
				flag = $urandom_range(0, 1) ? 3'd2 : 3'($urandom_range(4, 7));
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
			offer_word(mk_in(pr_sync, 1'b0), -1, '0);
			offer_word(mk_in({flag, 29'(len)}, 1'b0), -1, '0);
			for (int w = 0; w < (len + 3) / 4; w++)
				offer_word(mk_in($urandom, 1'b0), -1, '0);
		end
	endtask

	// Receiver: its own stall pattern from one of three modes, plus one long hold-off
	initial begin
		int cyc;
		int mode;
		logic [15:0] stall_pat;
		cyc = 0;
		mode = 0;
		stall_pat = 16'hffff;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (cyc % 64 == 0) begin
					mode = $urandom_range(0, 2);
					stall_pat = 16'($urandom);
				end
				case (mode)
					0: begin
						res_ready <= 1'b1;
					end
					1: begin
						res_ready <= stall_pat[cyc % 16];
					end
					default: begin
						res_ready <= ($urandom_range(0, 2) != 0);
					end
				endcase
				cyc++;
			end
		end
	end

	// Compare every accepted result with the oldest one awaited
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (awaited_res.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected result: byte %02h valid %b last %b code %0d",
						res.payload_byte, res.byte_valid, res.record_last, res.error_code);
				fail_count++;
			end else begin
				want_res = awaited_res.pop_front();
				if (res.payload_byte !== want_res.payload_byte ||
						res.byte_valid !== want_res.byte_valid ||
						res.record_last !== want_res.record_last ||
						res.error_code !== want_res.error_code) begin
					if (fail_count < 10)
						$display({"mismatch: want byte %02h valid %b last %b code %0d,",
							" got byte %02h valid %b last %b code %0d"},
							want_res.payload_byte, want_res.byte_valid,
							want_res.record_last, want_res.error_code,
							res.payload_byte, res.byte_valid, res.record_last,
							res.error_code);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#LIMIT_NS;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [31:0] s;
		int variant;
		arst_n     = 1'b0;
		sync_we    = 1'b0;
		sync_wdata = '0;
		word_valid = 1'b0;
		word       = '0;
		pr_sync    = rsd_pkg::SYNC_RESET;
		pr_phase   = rsd_pkg::PH_MAGIC;
		pr_cont    = 1'b0;
		pr_split   = 1'b0;
		pr_left    = '0;

		s = rsd_pkg::SYNC_RESET;
		// Directed table: record shapes and flag orders under the default sync word
		add_dir_row(mk_row(32'h0000_0000, 1'b1, 0, '0));   // end between records
		add_dir_row(mk_row(s, 1'b0, 0, '0));
		add_dir_row(mk_row(32'h0000_0000, 1'b0, 1,        // empty record
			mk_res(8'h00, 1'b0, 1'b1, rsd_pkg::ERR_NONE)));
		add_dir_row(mk_row(s, 1'b0, -1, '0));
		add_dir_row(mk_row(32'h0000_0005, 1'b0, -1, '0));
		add_dir_row(mk_row(32'hffff_ffff, 1'b0, -1, '0));
		add_dir_row(mk_row(32'h0000_0000, 1'b0, -1, '0));  // last byte, pad dropped
		add_dir_row(mk_row(32'hffff_ffff, 1'b1, 0, '0));   // end ignores data
		add_dir_row(mk_row(s, 1'b0, -1, '0));
		add_dir_row(mk_row(32'h2000_0000, 1'b0, -1, '0));  // empty first part
		add_dir_row(mk_row(s, 1'b0, -1, '0));
		add_dir_row(mk_row(32'h8000_0002, 1'b0, -1, '0));  // flag four continues
		add_dir_row(mk_row(32'ha5a5_5a5a, 1'b0, -1, '0));
		add_dir_row(mk_row(s, 1'b0, -1, '0));
		add_dir_row(mk_row(32'h4000_0003, 1'b0, -1, '0));  // middle part
		add_dir_row(mk_row(32'h1234_5678, 1'b0, -1, '0));
		add_dir_row(mk_row(s, 1'b0, -1, '0));
		add_dir_row(mk_row(32'h6000_0000, 1'b0, -1, '0));  // empty end marks separator
		add_dir_row(mk_row(s, 1'b0, -1, '0));
		add_dir_row(mk_row(32'he000_0001, 1'b0, -1, '0));  // flag seven opens a split
		add_dir_row(mk_row(32'hc3c3_3c3c, 1'b0, -1, '0));
		add_dir_row(mk_row(s, 1'b0, -1, '0));
		add_dir_row(mk_row(32'h6000_0004, 1'b0, -1, '0));
		add_dir_row(mk_row(32'h8765_4321, 1'b0, -1, '0));
		add_dir_row(mk_row(32'h0000_0000, 1'b1, 0, '0));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			offer_word(dir_rows[i].item, dir_rows[i].n_typed, dir_rows[i].typed);

		// Random records under several sync words, the extremes first
		load_sync(32'h0000_0000);
		while (words_sent < 25 + SEG_WORDS)
			gen_record();
		load_sync(32'hffff_ffff);
		hold_req = 1'b1;   // keep offering while the receiver holds off
		while (words_sent < 25 + 2 * SEG_WORDS)
			gen_record();
		load_sync($urandom);
		while (words_sent < 25 + 3 * SEG_WORDS)
			gen_record();
		load_sync($urandom);
		while (words_sent < 25 + 4 * SEG_WORDS)
			gen_record();

		// One fault ends the run, since the block halts until reset
		s = pr_sync;
		case ($urandom_range(1, 4))
			1: begin
				add_tail_row(mk_row(~s, 1'b0, 1,
					mk_res(8'h00, 1'b0, 1'b0, rsd_pkg::ERR_MAGIC)));
			end
			2: begin
				add_tail_row(mk_row(s, 1'b0, -1, '0));
				add_tail_row(mk_row(32'h4000_0004, 1'b0, 1,
					mk_res(8'h00, 1'b0, 1'b0, rsd_pkg::ERR_CONT_AT_START)));
			end
			3: begin
				add_tail_row(mk_row(s, 1'b0, -1, '0));
				add_tail_row(mk_row(32'h2000_0000, 1'b0, -1, '0));
				add_tail_row(mk_row(s, 1'b0, -1, '0));
				add_tail_row(mk_row(32'h0000_0001, 1'b0, 1,
					mk_res(8'h00, 1'b0, 1'b0, rsd_pkg::ERR_START_IN_SPLIT)));
			end
			default: begin
				// cut the stream after a magic word, inside a payload or between parts
				variant = $urandom_range(0, 2);
				add_tail_row(mk_row(s, 1'b0, -1, '0));
				if (variant == 1) begin
					add_tail_row(mk_row(32'h0000_0008, 1'b0, -1, '0));
					add_tail_row(mk_row($urandom, 1'b0, -1, '0));
				end else if (variant == 2) begin
					add_tail_row(mk_row(32'h2000_0001, 1'b0, -1, '0));
					add_tail_row(mk_row($urandom, 1'b0, -1, '0));
				end
				add_tail_row(mk_row($urandom, 1'b1, 1,
					mk_res(8'h00, 1'b0, 1'b0, rsd_pkg::ERR_TRUNC)));
			end
		endcase
		// once halted, drop everything
		repeat (4)
			add_tail_row(mk_row($urandom, 1'($urandom_range(0, 1)), -1, '0));
		foreach (tail_rows[i])
			offer_word(tail_rows[i].item, tail_rows[i].n_typed, tail_rows[i].typed);

		word_valid <= 1'b0;
		while (awaited_res.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
